// File: rtl/mcmct_pkg.sv
`default_nettype none

package mcmct_pkg;

    // Field widths of the item and result words
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 8;
    localparam int TIMEOUT_W = 32;
    localparam int MASK_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int ACC_W     = 11;

    // Default bank configuration
    localparam int NUM_CHANNELS_DEF  = 8;
    localparam int MS_PER_SECOND_DEF = 1000;

    // Operation codes
    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_TICK  = 2'd0;
    localparam opcode_t OP_ARM   = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    // Per-channel controls for one processed word
    typedef struct packed {
        logic tick;   // tick with a nonzero elapsed count
        logic arm;    // load timeout and start counting
        logic clear;  // drop both marks
        logic drop;   // channel 0 expiry handoff to the indicator
    } chan_ctl_t;

endpackage

`default_nettype wire

// File: rtl/multi_channel_ms_countdown_timers_unit.sv
`default_nettype none

// Bank of millisecond countdown timers.
// Input channel (in_valid / in_stall) carries one word per operation: a tick
// with a sample of the free-running counter's upper byte, an arm of a channel
// with a timeout, or a clear of a channel's marks. Every word yields exactly
// one result word on the output channel (out_valid / out_stall) holding the
// event and active masks, the seconds timestamp, the tick count of the last
// completed second, the second-completed flag and the indicator state.
// A word is held first in the input register, then in the result register.
// Throughput is one word per cycle while out_stall is low; all channels update
// in parallel, one subtract and compare per channel, between the two registers.
// When out_stall is high the result register holds, the input register fills
// and then in_stall rises in the same cycle as the blockage reaches it.
// Reset clears all timers, marks, counters and the indicator; the first tick
// after reset only captures the counter sample.
module multi_channel_ms_countdown_timers_unit
#(
    parameter int NUM_CHANNELS  = mcmct_pkg::NUM_CHANNELS_DEF,
    parameter int MS_PER_SECOND = mcmct_pkg::MS_PER_SECOND_DEF
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire [1:0]                           opcode,
    input  wire [mcmct_pkg::SAMPLE_W-1:0]       counter_sample,
    input  wire [mcmct_pkg::CHAN_W-1:0]         channel,
    input  wire [mcmct_pkg::TIMEOUT_W-1:0]      timeout,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [mcmct_pkg::MASK_W-1:0]        event_mask,
    output logic [mcmct_pkg::MASK_W-1:0]        active_mask,
    output logic [mcmct_pkg::COUNT_W-1:0]       seconds,
    output logic [mcmct_pkg::COUNT_W-1:0]       ticks_last_second,
    output logic                                second_done,
    output logic                                indicator_on
);

    localparam int SUM_W = mcmct_pkg::ACC_W + 1;

    // Input register
    logic                                 in_valid_reg;
    mcmct_pkg::opcode_t                   op_reg;
    logic [mcmct_pkg::SAMPLE_W-1:0]       sample_reg;
    logic [mcmct_pkg::CHAN_W-1:0]         chan_reg;
    logic [mcmct_pkg::TIMEOUT_W-1:0]      timeout_reg;

    // Shared timing state
    logic [mcmct_pkg::SAMPLE_W-1:0]       prev_sample_reg;
    logic [mcmct_pkg::SAMPLE_W-1:0]       prev_sample_next;
    logic                                 seen_reg;
    logic                                 seen_next;
    logic [mcmct_pkg::ACC_W-1:0]          acc_reg;
    logic [mcmct_pkg::ACC_W-1:0]          acc_next;
    logic [mcmct_pkg::COUNT_W-1:0]        second_cnt_reg;
    logic [mcmct_pkg::COUNT_W-1:0]        second_cnt_next;
    logic [mcmct_pkg::COUNT_W-1:0]        tick_cnt_reg;
    logic [mcmct_pkg::COUNT_W-1:0]        tick_cnt_next;
    logic [mcmct_pkg::COUNT_W-1:0]        tick_cnt_inc;
    logic [mcmct_pkg::COUNT_W-1:0]        latched_reg;
    logic [mcmct_pkg::COUNT_W-1:0]        latched_next;
    logic                                 indicator_reg;
    logic                                 indicator_next;

    // Result register
    logic                                 out_valid_reg;
    logic [mcmct_pkg::MASK_W-1:0]         event_mask_reg;
    logic [mcmct_pkg::MASK_W-1:0]         active_mask_reg;
    logic [mcmct_pkg::COUNT_W-1:0]        seconds_reg;
    logic [mcmct_pkg::COUNT_W-1:0]        ticks_last_reg;
    logic                                 second_done_reg;
    logic                                 indicator_out_reg;

    // Processing controls
    logic                                 advance;
    logic                                 go;
    logic                                 is_tick;
    logic                                 is_arm;
    logic                                 is_clear;
    logic                                 tick_counted;
    logic                                 same_sample;
    logic                                 tick_full;
    logic                                 chan_ok;
    logic                                 sec_hit;
    logic                                 ind_set;
    logic [mcmct_pkg::SAMPLE_W-1:0]       elapsed;
    logic [SUM_W-1:0]                     acc_sum;
    logic [SUM_W-1:0]                     acc_wrap;

    // Channel bank signals
    mcmct_pkg::chan_ctl_t                 ctl [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]              expire;
    logic [NUM_CHANNELS-1:0]              active_next;
    logic [NUM_CHANNELS-1:0]              event_next;
    logic [mcmct_pkg::MASK_W-1:0]         event_mask_next;
    logic [mcmct_pkg::MASK_W-1:0]         active_mask_next;

    // Move words through when the result register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign go       = in_valid_reg && advance;

    // Decode the held word
    assign is_tick  = go && (op_reg == mcmct_pkg::OP_TICK);
    assign is_arm   = go && (op_reg == mcmct_pkg::OP_ARM);
    assign is_clear = go && (op_reg == mcmct_pkg::OP_CLEAR);
    assign chan_ok  = {{(32-mcmct_pkg::CHAN_W){1'b0}}, chan_reg} < 32'(NUM_CHANNELS);

    assign tick_counted = is_tick && seen_reg;
    assign same_sample  = (sample_reg == prev_sample_reg);
    assign tick_full    = tick_counted && !same_sample;
    assign elapsed      = sample_reg - prev_sample_reg;
    assign tick_cnt_inc = tick_cnt_reg + 1'b1;

    assign acc_sum  = {1'b0, acc_reg} + {{(SUM_W-mcmct_pkg::SAMPLE_W){1'b0}}, elapsed};
    assign acc_wrap = acc_sum - SUM_W'(MS_PER_SECOND);
    assign sec_hit  = tick_full && (acc_sum >= SUM_W'(MS_PER_SECOND));

    // Hand channel 0's expiry to the indicator
    assign ind_set = tick_full && (event_next[0] || expire[0]);

    // Drive the channel bank
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CHANNELS; gi++)
        begin : g_chan
            logic hit;
            assign hit = chan_ok && (32'(chan_reg) == 32'(gi));
            assign ctl[gi].tick  = tick_full;
            assign ctl[gi].arm   = is_arm && hit;
            assign ctl[gi].clear = is_clear && hit;
            if (gi == 0)
            begin : g_drop
                assign ctl[gi].drop = tick_full && expire[0];
            end
            else
            begin : g_nodrop
                assign ctl[gi].drop = 1'b0;
            end

            mcmct_channel u_channel
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl[gi]),
                .elapsed     (elapsed),
                .timeout     (timeout_reg),
                .expire      (expire[gi]),
                .active_next (active_next[gi]),
                .event_next  (event_next[gi])
            );
        end

        // Show only the channels that fit the masks
        for (gi = 0; gi < mcmct_pkg::MASK_W; gi++)
        begin : g_mask
            if (gi < NUM_CHANNELS)
            begin : g_used
                assign event_mask_next[gi]  = event_next[gi];
                assign active_mask_next[gi] = active_next[gi];
            end
            else
            begin : g_unused
                assign event_mask_next[gi]  = 1'b0;
                assign active_mask_next[gi] = 1'b0;
            end
        end
    endgenerate

    // Advance the sample, accumulator and counters
    always_comb
    begin
        prev_sample_next = prev_sample_reg;
        seen_next        = seen_reg;
        acc_next         = acc_reg;
        second_cnt_next  = second_cnt_reg;
        tick_cnt_next    = tick_cnt_reg;
        latched_next     = latched_reg;
        indicator_next   = indicator_reg;
        if (is_tick)
        begin
            seen_next = 1'b1;
            if (!seen_reg || !same_sample)
            begin
                prev_sample_next = sample_reg;
            end
        end
        if (tick_counted)
        begin
            tick_cnt_next = tick_cnt_inc;
        end
        if (tick_full)
        begin
            acc_next = acc_sum[mcmct_pkg::ACC_W-1:0];
        end
        if (sec_hit)
        begin
            acc_next        = acc_wrap[mcmct_pkg::ACC_W-1:0];
            latched_next    = tick_cnt_inc;
            tick_cnt_next   = '0;
            second_cnt_next = second_cnt_reg + 1'b1;
        end
        if (is_arm && chan_ok && (chan_reg == '0))
        begin
            indicator_next = 1'b0;
        end
        if (ind_set)
        begin
            indicator_next = 1'b1;
        end
    end

    // Hold shared state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            seen_reg        <= 1'b0;
            acc_reg         <= '0;
            second_cnt_reg  <= '0;
            tick_cnt_reg    <= '0;
            latched_reg     <= '0;
            indicator_reg   <= 1'b0;
        end
        else
        begin
            prev_sample_reg <= prev_sample_next;
            seen_reg        <= seen_next;
            acc_reg         <= acc_next;
            second_cnt_reg  <= second_cnt_next;
            tick_cnt_reg    <= tick_cnt_next;
            latched_reg     <= latched_next;
            indicator_reg   <= indicator_next;
        end
    end

    // Capture an incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg      <= opcode;
            sample_reg  <= counter_sample;
            chan_reg    <= channel;
            timeout_reg <= timeout;
        end
    end

    // Load the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            event_mask_reg    <= event_mask_next;
            active_mask_reg   <= active_mask_next;
            seconds_reg       <= second_cnt_next;
            ticks_last_reg    <= latched_next;
            second_done_reg   <= sec_hit;
            indicator_out_reg <= indicator_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign event_mask        = event_mask_reg;
    assign active_mask       = active_mask_reg;
    assign seconds           = seconds_reg;
    assign ticks_last_second = ticks_last_reg;
    assign second_done       = second_done_reg;
    assign indicator_on      = indicator_out_reg;

endmodule

`default_nettype wire

// File: rtl/mcmct_channel.sv
`default_nettype none

module mcmct_channel
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  mcmct_pkg::chan_ctl_t                ctl,
    input  wire [mcmct_pkg::SAMPLE_W-1:0]       elapsed,
    input  wire [mcmct_pkg::TIMEOUT_W-1:0]      timeout,
    output logic                                expire,
    output logic                                active_next,
    output logic                                event_next
);

    logic [mcmct_pkg::TIMEOUT_W-1:0] remaining_reg;
    logic [mcmct_pkg::TIMEOUT_W-1:0] remaining_next;
    logic                            active_reg;
    logic                            event_reg;
    logic [mcmct_pkg::TIMEOUT_W-1:0] elapsed_ext;

    assign elapsed_ext = {{(mcmct_pkg::TIMEOUT_W-mcmct_pkg::SAMPLE_W){1'b0}}, elapsed};

    // Detect the channel running out on this tick
    assign expire = ctl.tick && active_reg && (remaining_reg <= elapsed_ext);

    // Work out the next countdown state
    always_comb
    begin
        remaining_next = remaining_reg;
        active_next    = active_reg;
        event_next     = event_reg;
        if (ctl.arm)
        begin
            remaining_next = timeout;
            active_next    = 1'b1;
            event_next     = 1'b0;
        end
        else if (ctl.clear)
        begin
            active_next = 1'b0;
            event_next  = 1'b0;
        end
        else if (ctl.tick && active_reg)
        begin
            if (expire)
            begin
                remaining_next = '0;
                active_next    = 1'b0;
                event_next     = 1'b1;
            end
            else
            begin
                remaining_next = remaining_reg - elapsed_ext;
            end
        end
        if (ctl.drop)
        begin
            active_next = 1'b0;
            event_next  = 1'b0;
        end
    end

    // Hold the countdown state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            active_reg    <= 1'b0;
            event_reg     <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
            event_reg     <= event_next;
        end
    end

endmodule

`default_nettype wire
